/* rtl/core/sus_pkg.sv */
// Shared types and codes for the sorted unique key set.
package sus_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } sus_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_CHANGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } sus_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_DECIDE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_READ,
    S_RESP
  } sus_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [7:0]  position;
  } sus_req_t;

  typedef struct packed {
    logic        found;
    logic [8:0]  slot;
    logic [31:0] entry_value;
    logic [8:0]  entries_used;
    logic [1:0]  status;
  } sus_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic probe_rd;
    logic probe_cmp;
    logic init_up;
    logic init_down;
    logic up_step;
    logic down_step;
    logic place_key;
    logic drop_key;
    logic read_entry;
    logic rsp_load;
  } sus_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic is_add;
    logic is_remove;
    logic search_done;
    logic hit;
    logic full;
    logic up_done;
    logic down_done;
    logic out_busy;
  } sus_sts_t;

endpackage

/* rtl/core/sus_dp.sv */
// Datapath of the sorted unique key set: key store, search bounds, shifter and result register.
module sus_dp #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sus_pkg::sus_req_t in_req_i,
  input  sus_pkg::sus_ctl_t ctl_i,
  output sus_pkg::sus_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output sus_pkg::sus_rsp_t out_rsp_o
);
  import sus_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rdata_q;

  logic [1:0]           cmd_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [7:0]           pos_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        lo_q, hi_q, mid_q, cur_q;
  logic                 eq_q, full_q, wb_valid_q, out_valid_q;
  logic [AW-1:0]        wb_addr_q;
  sus_rsp_t             rsp_q;

  logic [CW-1:0]        mid;
  logic                 in_range, up_more, down_more;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  sus_rsp_t             rsp_d;

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign in_range  = 32'(pos_q) < 32'(count_q);
  assign up_more   = cur_q > lo_q;
  assign down_more = cur_q < count_q;

  // Read port: one address per cycle, chosen by the active operation.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(mid);
    if (ctl_i.probe_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(mid);
    end else if (ctl_i.read_entry) begin
      rd_en   = in_range;
      rd_addr = AW'(pos_q);
    end else if (ctl_i.up_step) begin
      rd_en   = up_more;
      rd_addr = AW'(cur_q - CW'(1));
    end else if (ctl_i.down_step) begin
      rd_en   = down_more;
      rd_addr = AW'(cur_q);
    end
  end

  assign wr_en   = ctl_i.place_key || ((ctl_i.up_step || ctl_i.down_step) && wb_valid_q);
  assign wr_addr = ctl_i.place_key ? AW'(lo_q) : wb_addr_q;
  assign wr_data = ctl_i.place_key ? key_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Request fields and search bounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q      <= CMD_QUERY;
      key_q      <= '0;
      pos_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      mid_q      <= '0;
      cur_q      <= '0;
      eq_q       <= 1'b0;
      full_q     <= 1'b0;
      wb_valid_q <= 1'b0;
      wb_addr_q  <= '0;
    end else begin
      if (ctl_i.load_req) begin
        cmd_q  <= in_req_i.command;
        key_q  <= KEY_WIDTH'(in_req_i.key);
        pos_q  <= in_req_i.position;
        lo_q   <= '0;
        hi_q   <= count_q;
        eq_q   <= 1'b0;
        full_q <= (32'(count_q) >= 32'(CAPACITY));
      end
      if (ctl_i.probe_rd) begin
        mid_q <= mid;
      end
      // The last probe that lowers hi sits at the lower bound, so its equality is the hit.
      if (ctl_i.probe_cmp) begin
        if (rdata_q < key_q) begin
          lo_q <= mid_q + CW'(1);
        end else begin
          hi_q <= mid_q;
          eq_q <= (rdata_q == key_q);
        end
      end
      if (ctl_i.init_up) begin
        cur_q      <= count_q;
        wb_valid_q <= 1'b0;
      end
      if (ctl_i.init_down) begin
        cur_q      <= lo_q + CW'(1);
        wb_valid_q <= 1'b0;
      end
      // Each step reads the next entry, if any remain, and writes the one read the cycle before.
      if (ctl_i.up_step) begin
        if (up_more) begin
          cur_q      <= cur_q - CW'(1);
          wb_valid_q <= 1'b1;
          wb_addr_q  <= AW'(cur_q);
        end else begin
          wb_valid_q <= 1'b0;
        end
      end
      if (ctl_i.down_step) begin
        if (down_more) begin
          cur_q      <= cur_q + CW'(1);
          wb_valid_q <= 1'b1;
          wb_addr_q  <= AW'(cur_q - CW'(1));
        end else begin
          wb_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.place_key) begin
      count_q <= count_q + CW'(1);
    end else if (ctl_i.drop_key) begin
      count_q <= count_q - CW'(1);
    end
  end

  // Result assembly; the count already reflects any change made by this request.
  always_comb begin
    rsp_d              = '0;
    rsp_d.entries_used = 9'(32'(count_q));
    if (cmd_q == CMD_READ) begin
      rsp_d.slot  = 9'(pos_q);
      rsp_d.found = in_range;
      if (in_range) begin
        rsp_d.entry_value = 32'(rdata_q);
        rsp_d.status      = ST_DONE;
      end else begin
        rsp_d.status = ST_RANGE;
      end
    end else begin
      rsp_d.slot  = 9'(32'(lo_q));
      rsp_d.found = eq_q;
      unique case (cmd_q)
        CMD_ADD: begin
          if (eq_q) begin
            rsp_d.status = ST_NO_CHANGE;
          end else if (full_q) begin
            rsp_d.status = ST_FULL;
          end else begin
            rsp_d.status = ST_DONE;
          end
        end
        CMD_REMOVE: rsp_d.status = eq_q ? ST_DONE : ST_NO_CHANGE;
        default:    rsp_d.status = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.rsp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign sts_o.is_read     = (cmd_q == CMD_READ);
  assign sts_o.is_add      = (cmd_q == CMD_ADD);
  assign sts_o.is_remove   = (cmd_q == CMD_REMOVE);
  assign sts_o.search_done = (lo_q >= hi_q);
  assign sts_o.hit         = eq_q;
  assign sts_o.full        = full_q;
  assign sts_o.up_done     = !up_more && !wb_valid_q;
  assign sts_o.down_done   = !down_more && !wb_valid_q;
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(CAPACITY))
    else $error("key count exceeds capacity");

  a_place_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.place_key |-> (32'(count_q) < 32'(CAPACITY)) && !eq_q)
    else $error("key placed into a full set or over a present key");

  a_probe_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.probe_cmp |-> (mid_q >= lo_q) && (mid_q < hi_q))
    else $error("probe index outside the search window");

  a_rsp_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rsp_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

/* rtl/core/sus_ctrl.sv */
// Controller state machine of the sorted unique key set.
module sus_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sus_pkg::sus_sts_t sts_i,
  output sus_pkg::sus_ctl_t ctl_o
);
  import sus_pkg::*;

  sus_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_req = 1'b1;
          state_d        = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts_i.is_read) begin
          state_d = S_READ;
        end else if (sts_i.search_done) begin
          state_d = S_DECIDE;
        end else begin
          ctl_o.probe_rd = 1'b1;
          state_d        = S_COMPARE;
        end
      end
      S_COMPARE: begin
        ctl_o.probe_cmp = 1'b1;
        state_d         = S_PROBE;
      end
      S_DECIDE: begin
        if (sts_i.is_add && !sts_i.hit && !sts_i.full) begin
          ctl_o.init_up = 1'b1;
          state_d       = S_SHIFT_UP;
        end else if (sts_i.is_remove && sts_i.hit) begin
          ctl_o.init_down = 1'b1;
          state_d         = S_SHIFT_DOWN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SHIFT_UP: begin
        if (sts_i.up_done) begin
          ctl_o.place_key = 1'b1;
          state_d         = S_RESP;
        end else begin
          ctl_o.up_step = 1'b1;
        end
      end
      S_SHIFT_DOWN: begin
        if (sts_i.down_done) begin
          ctl_o.drop_key = 1'b1;
          state_d        = S_RESP;
        end else begin
          ctl_o.down_step = 1'b1;
        end
      end
      S_READ: begin
        ctl_o.read_entry = 1'b1;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          ctl_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_PROBE))
    else $error("accepted request did not start a search");

  a_shift_only_on_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_UP) |-> (sts_i.is_add && !sts_i.hit && !sts_i.full))
    else $error("insert shift entered for a request that changes nothing");

endmodule

/* rtl/core/sorted_unique_key_set.sv */
// Top level of the sorted unique key set: controller plus datapath.
//
// Holds up to CAPACITY unique keys in ascending order in a single memory with one
// write port and one registered read port. A request carries add, remove, query or
// read; one result per request. Add, remove and query run a binary search in which
// each probe reads, then compares. An add of a new key to a set with room then moves
// the larger keys up one entry and a remove of a present key moves them down, one
// entry per cycle through the memory ports. When any key moves, a final step writes
// the last moved entry; the key is then placed or dropped. A read skips the search.
// One request is in work at a time; a new request is taken as soon as the previous
// result is in the output register, even if it is not yet taken.
// The store needs no clearing after reset: only entries below the count are read.
module sorted_unique_key_set #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sus_pkg::sus_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sus_pkg::sus_rsp_t out_rsp_o
);
  import sus_pkg::*;

  sus_ctl_t ctl;
  sus_sts_t sts;

  sus_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  sus_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
